@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the RTL checks of the stream core.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CER_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define CER_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/cer_pkg.sv @@
// ---------------------------------------------------------------------------
// cer_pkg
// Shared types and constants of the 3x3 cross erosion stream core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cer_pkg;

  // Field and bus widths
  localparam int PIX_W      = 8;
  localparam int IMG_W_BITS = 11;
  localparam int IMG_H_BITS = 16;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  // Register reset values
  localparam logic [IMG_W_BITS-1:0] RST_IMAGE_WIDTH  = 11'd640;
  localparam logic [IMG_H_BITS-1:0] RST_IMAGE_HEIGHT = 16'd480;

  // Register index, taken from the word address
  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_t;

  // Request opcodes
  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } opcode_t;

  // Per-request control decoded from the scan position
  typedef struct packed {
    logic has_result;  // request lies below row 0 and yields a result
    logic interior;    // centre pixel is off the image border
    logic last;        // result belongs to the final pixel of the image
    logic bank;        // line store bank of the current row
  } item_ctrl_t;

  // Neighbourhood read from the line store
  typedef struct packed {
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] center;
    logic [PIX_W-1:0] right;
    logic [PIX_W-1:0] above;
  } window_t;

endpackage

@@ src/cer_ram.sv @@
// ---------------------------------------------------------------------------
// cer_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cer_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and read the old contents on a clash
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/cer_cfg_regs.sv @@
// ---------------------------------------------------------------------------
// cer_cfg_regs
// APB-style register file holding the image geometry.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cer_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cer_pkg::ADDR_W-1:0]      paddr,
  input  logic [cer_pkg::DATA_W-1:0]      pwdata,
  output logic [cer_pkg::DATA_W-1:0]      prdata,
  output logic                            pready,
  output logic [cer_pkg::IMG_W_BITS-1:0]  image_width,
  output logic [cer_pkg::IMG_H_BITS-1:0]  image_height
);

  import cer_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[2]);

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RST_IMAGE_WIDTH;
      image_height <= RST_IMAGE_HEIGHT;
    end else if (wr_en) begin
      unique case (idx)
        REG_IMAGE_WIDTH:  image_width  <= pwdata[IMG_W_BITS-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[IMG_H_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_IMAGE_WIDTH:  prdata = DATA_W'(image_width);
      REG_IMAGE_HEIGHT: prdata = DATA_W'(image_height);
      default:          prdata = '0;
    endcase
  end

endmodule

@@ src/cer_scan_ctrl.sv @@
// ---------------------------------------------------------------------------
// cer_scan_ctrl
// Raster position counters and per-request control decode.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cer_scan_ctrl #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [cer_pkg::IMG_W_BITS-1:0]  image_width,
  input  logic [cer_pkg::IMG_H_BITS-1:0]  image_height,
  input  logic                            accept,
  input  logic                            opcode,
  input  logic [cer_pkg::PIX_W-1:0]       pixel_value,
  output logic [$clog2(MAX_WIDTH)-1:0]    col,
  output cer_pkg::item_ctrl_t             ctrl,
  output logic [cer_pkg::PIX_W-1:0]       pix
);

  import cer_pkg::*;

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int MW_B = $clog2(MAX_WIDTH + 1);
  localparam int WW   = (IMG_W_BITS > MW_B) ? IMG_W_BITS : MW_B;
  localparam int HW   = IMG_H_BITS;

  logic [AW-1:0] column, column_next;
  logic [HW-1:0] row, row_next;

  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic          wrap;
  logic [HW:0]   row_inc;
  logic [HW:0]   row_adv;
  logic [HW-1:0] r;
  logic [WW-1:0] c_plus1;

  // Clamp the geometry to what the store can hold; a zero size counts as one
  always_comb begin
    if (image_width == '0) begin
      eff_w = WW'(1);
    end else if (WW'(image_width) > WW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(image_width);
    end
    eff_h = (image_height == '0) ? HW'(1) : image_height;
  end

  // Settle the position after a geometry change
  always_comb begin
    wrap    = WW'(column) >= eff_w;
    row_inc = {1'b0, row} + (HW+1)'(wrap);
    r       = (row_inc > {1'b0, eff_h}) ? '0 : row_inc[HW-1:0];
    col     = wrap ? '0 : column;
    c_plus1 = WW'(col) + WW'(1);
  end

  // Decode the request's role in the image
  always_comb begin
    ctrl.has_result = r != '0;
    ctrl.interior   = (col != '0) && (c_plus1 < eff_w) && (r != HW'(1)) && (r < eff_h);
    ctrl.last       = (r == eff_h) && (c_plus1 == eff_w);
    ctrl.bank       = r[0];
    pix             = (opcode == OP_FLUSH) ? '0 : pixel_value;
  end

  // Advance to the next raster position
  always_comb begin
    row_adv = {1'b0, r} + (HW+1)'(1);
    if (c_plus1 >= eff_w) begin
      column_next = '0;
      row_next    = (row_adv > {1'b0, eff_h}) ? '0 : row_adv[HW-1:0];
    end else begin
      column_next = c_plus1[AW-1:0];
      row_next    = r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      row    <= '0;
    end else if (accept) begin
      column <= column_next;
      row    <= row_next;
    end
  end

endmodule

@@ src/cer_line_store.sv @@
// ---------------------------------------------------------------------------
// cer_line_store
// Two-row line store, one bank per row parity, read as a cross window.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cer_line_store #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          access,
  input  logic [$clog2(MAX_WIDTH)-1:0]  col,
  input  logic                          bank,
  input  logic [cer_pkg::PIX_W-1:0]     wr_data,
  output cer_pkg::window_t              window
);

  import cer_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  logic [AW-1:0]    addr_left, addr_right;
  logic [PIX_W-1:0] lft_q [2];
  logic [PIX_W-1:0] cen_q [2];
  logic [PIX_W-1:0] rgt_q [2];
  logic             rd_bank;

  assign addr_left  = col - AW'(1);
  assign addr_right = col + AW'(1);

  // Each bank keeps three copies so that left, centre and right read together
  for (genvar b = 0; b < 2; b++) begin : g_bank
    logic we;
    assign we = access && (bank == 1'(b));

    cer_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_left (
      .clk(clk), .we(we), .waddr(col), .wdata(wr_data),
      .re(access), .raddr(addr_left), .rdata(lft_q[b])
    );

    cer_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_center (
      .clk(clk), .we(we), .waddr(col), .wdata(wr_data),
      .re(access), .raddr(col), .rdata(cen_q[b])
    );

    cer_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_right (
      .clk(clk), .we(we), .waddr(col), .wdata(wr_data),
      .re(access), .raddr(addr_right), .rdata(rgt_q[b])
    );
  end

  // Hold the bank of the read in flight
  always_ff @(posedge clk) begin
    if (access) begin
      rd_bank <= bank;
    end
  end

  // Previous row comes from the other bank; above from the current one
  always_comb begin
    window.left   = rd_bank ? lft_q[0] : lft_q[1];
    window.center = rd_bank ? cen_q[0] : cen_q[1];
    window.right  = rd_bank ? rgt_q[0] : rgt_q[1];
    window.above  = rd_bank ? cen_q[1] : cen_q[0];
  end

endmodule

@@ src/cer_out_stage.sv @@
// ---------------------------------------------------------------------------
// cer_out_stage
// Evaluate the erosion for one request and hold the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cer_out_stage (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  cer_pkg::item_ctrl_t          ctrl_in,
  input  logic [cer_pkg::PIX_W-1:0]    pix_in,
  input  cer_pkg::window_t             window,
  output logic                         in_ready,
  output logic [cer_pkg::PIX_W-1:0]    eroded_value,
  output logic                         last_pixel,
  output logic                         out_valid,
  input  logic                         out_ready
);

  import cer_pkg::*;

  logic             s1_valid;
  item_ctrl_t       s1_ctrl;
  logic [PIX_W-1:0] s1_pix;
  logic             s1_adv;
  logic             load;
  logic             keep;
  logic [PIX_W-1:0] res;

  // Advance when the result register is free, or drop a request with no result
  assign s1_adv   = s1_valid && (!s1_ctrl.has_result || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign load     = s1_adv && s1_ctrl.has_result;

  // Keep the centre only if it is off the border and it and all four neighbours are nonzero
  always_comb begin
    keep = s1_ctrl.interior && (window.center != '0) && (window.left != '0) &&
           (window.right != '0) && (window.above != '0) && (s1_pix != '0);
    res  = keep ? window.center : '0;
  end

  // Evaluation stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctrl <= ctrl_in;
      s1_pix  <= pix_in;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      eroded_value <= res;
      last_pixel   <= s1_ctrl.last;
    end
  end

endmodule

@@ src/cross_erosion_3x3_stream_core.sv @@
// ---------------------------------------------------------------------------
// cross_erosion_3x3_stream_core
// Streaming 3x3 cross erosion of 8-bit gray images in raster order.
// ---------------------------------------------------------------------------
// Usage:
//   Input requests (opcode, pixel_value) arrive on in_valid/in_ready in raster
//   order; after the image one row of flush requests (opcode = 1) follows.
//   Results (eroded_value, last_pixel) leave on out_valid/out_ready, one per
//   request from row 1 onwards, so each result lags its input by one row.
//   last_pixel marks the result of the final pixel of the image.
//   Geometry is set through the APB port: image_width at 0x0, image_height
//   at 0x4; write it only while no request is in flight.
//   Throughput is one request per cycle while the receiver keeps up. Accepting
//   a request reads the line store and loads the evaluation stage, which then
//   loads the result register. When the receiver stalls, one more request is
//   taken into the evaluation stage; in_ready drops only once both it and the
//   result register are full.
//   Reset returns the scan to row 0, column 0 and restores 640 x 480; the
//   line store is not cleared and needs no clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module cross_erosion_3x3_stream_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cer_pkg::ADDR_W-1:0]  paddr,
  input  logic [cer_pkg::DATA_W-1:0]  pwdata,
  output logic [cer_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        opcode,
  input  logic [cer_pkg::PIX_W-1:0]   pixel_value,
  input  logic                        in_valid,
  output logic                        in_ready,
  output logic [cer_pkg::PIX_W-1:0]   eroded_value,
  output logic                        last_pixel,
  output logic                        out_valid,
  input  logic                        out_ready
);

  import cer_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  logic [IMG_W_BITS-1:0] image_width;
  logic [IMG_H_BITS-1:0] image_height;
  logic                  accept;
  logic [AW-1:0]         col;
  item_ctrl_t            item_ctrl;
  logic [PIX_W-1:0]      pix;
  window_t               window;

  assign accept = in_valid && in_ready;

  // Geometry registers
  cer_cfg_regs u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .image_width(image_width), .image_height(image_height)
  );

  // Raster position and request decode
  cer_scan_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_scan (
    .clk(clk), .rst(rst), .image_width(image_width), .image_height(image_height),
    .accept(accept), .opcode(opcode), .pixel_value(pixel_value),
    .col(col), .ctrl(item_ctrl), .pix(pix)
  );

  // Two-row line store
  cer_line_store #(.MAX_WIDTH(MAX_WIDTH)) u_store (
    .clk(clk), .access(accept), .col(col), .bank(item_ctrl.bank),
    .wr_data(pix), .window(window)
  );

  // Evaluation and result register
  cer_out_stage u_out (
    .clk(clk), .rst(rst), .accept(accept), .ctrl_in(item_ctrl), .pix_in(pix),
    .window(window), .in_ready(in_ready), .eroded_value(eroded_value),
    .last_pixel(last_pixel), .out_valid(out_valid), .out_ready(out_ready)
  );

  // The final pixel lies on the bottom border and is always eroded
  `CER_ASSERT_IMPLIES(a_last_is_zero, clk, rst,
                      out_valid && last_pixel, eroded_value == '0,
                      "last pixel result not eroded")
  // Back-pressure reaches the input only when the result register is stalled
  `CER_ASSERT_IMPLIES(a_ready_only_on_stall, clk, rst,
                      !in_ready, out_valid && !out_ready,
                      "input stalled without output stall")
  // After the final pixel the scan restarts at row 0, column 0
  `CER_ASSERT_NEXT(a_scan_restart, clk, rst,
                   accept && item_ctrl.last && !(psel && penable && pwrite),
                   (col == '0) && !item_ctrl.has_result,
                   "scan did not restart after last pixel")

endmodule
